[rtl/ecmc_pkg.sv]
// ============================================================================
// ecmc_pkg
// Shared types, codes and constants for the encoder colour and mode control.
// ============================================================================
package ecmc_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_PIN  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_WRAP = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_HOLD_TICKS   = 3'd0;
    localparam logic [2:0] REG_STEP_DETENTS = 3'd1;
    localparam logic [2:0] REG_HUE_DETENTS  = 3'd2;
    localparam logic [2:0] REG_ANIM_COUNT   = 3'd3;
    localparam logic [2:0] REG_PERIOD_MIN   = 3'd4;
    localparam logic [2:0] REG_PERIOD_MAX   = 3'd5;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [6:0] HOLD_TICKS_RST   = 7'd100;
    localparam logic [6:0] STEP_DETENTS_RST = 7'd4;
    localparam logic [6:0] HUE_DETENTS_RST  = 7'd16;
    localparam logic [3:0] ANIM_COUNT_RST   = 4'd7;
    localparam logic [5:0] PERIOD_MIN_RST   = 6'd1;
    localparam logic [5:0] PERIOD_MAX_RST   = 6'd30;

    // State reset values.
    localparam logic [7:0] LEVEL_RST  = 8'd8;
    localparam logic [7:0] RED_RST    = 8'd127;
    localparam logic [5:0] PERIOD_RST = 6'd5;

    localparam logic [7:0] LEVEL_MAX = 8'd31;
    localparam logic [2:0] ANIM_LAST = 3'd7;
    localparam logic [1:0] CHAN_LAST = 2'd2;

    // Hue wheel sector boundaries.
    localparam logic [7:0] HUE_S5 = 8'd213;
    localparam logic [7:0] HUE_S4 = 8'd171;
    localparam logic [7:0] HUE_S3 = 8'd128;
    localparam logic [7:0] HUE_S2 = 8'd85;
    localparam logic [7:0] HUE_S1 = 8'd43;
    localparam logic [7:0] HUE_MID = 8'd170;
    localparam logic [7:0] FULL    = 8'd255;

    // Quadrature transition table, indexed by {previous phase, new phase}.
    localparam logic signed [1:0] STEP_TABLE [16] = '{
        2'sb00, 2'sb01, 2'sb11, 2'sb00,
        2'sb11, 2'sb00, 2'sb00, 2'sb01,
        2'sb01, 2'sb00, 2'sb00, 2'sb11,
        2'sb00, 2'sb11, 2'sb01, 2'sb00
    };

    typedef struct packed {
        logic [6:0] hold_ticks;
        logic [6:0] step_detents;
        logic [6:0] hue_detents;
        logic [3:0] anim_count;
        logic [5:0] period_min;
        logic [5:0] period_max;
    } ecmc_cfg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       enc_a_level;
        logic       enc_b_level;
        logic       button_level;
        logic       auto_mode;
    } ecmc_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] anim_index;
        logic [5:0] anim_period;
        logic       auto_advance;
        logic [1:0] channel_sel;
        logic       hue_active;
    } ecmc_result_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } ecmc_rgb_t;

    function automatic logic [7:0] mul6(input logic [7:0] v);
        return {v[5:0], 2'b00} + {v[6:0], 1'b0};
    endfunction

    // Six-sector hue wheel; products wrap in eight bits.
    function automatic ecmc_rgb_t hue_wheel(input logic [7:0] pos);
        ecmc_rgb_t c;
        if (pos >= HUE_S5)
        begin
            c.red = FULL; c.green = '0; c.blue = mul6(FULL - pos);
        end
        else if (pos >= HUE_S4)
        begin
            c.red = mul6(pos - HUE_MID); c.green = '0; c.blue = FULL;
        end
        else if (pos >= HUE_S3)
        begin
            c.red = '0; c.green = mul6(HUE_MID - pos); c.blue = FULL;
        end
        else if (pos >= HUE_S2)
        begin
            c.red = '0; c.green = FULL; c.blue = mul6(pos - HUE_S2);
        end
        else if (pos >= HUE_S1)
        begin
            c.red = mul6(HUE_S2 - pos); c.green = FULL; c.blue = '0;
        end
        else
        begin
            c.red = FULL; c.green = mul6(pos); c.blue = '0;
        end
        return c;
    endfunction

endpackage

[rtl/ecmc_req_if.sv]
// ============================================================================
// ecmc_req_if
// Request channel: one item per valid and ready handshake.
// ============================================================================
interface ecmc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       enc_a_level;
    logic       enc_b_level;
    logic       button_level;
    logic       auto_mode;

    modport source (output valid, output req_type, output enc_a_level,
                    output enc_b_level, output button_level, output auto_mode,
                    input ready);
    modport sink   (input valid, input req_type, input enc_a_level,
                    input enc_b_level, input button_level, input auto_mode,
                    output ready);
endinterface

[rtl/ecmc_res_if.sv]
// ============================================================================
// ecmc_res_if
// Result channel: one item per valid and ready handshake.
// ============================================================================
interface ecmc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] anim_index;
    logic [5:0] anim_period;
    logic       auto_advance;
    logic [1:0] channel_sel;
    logic       hue_active;

    modport source (output valid, output red, output green, output blue,
                    output anim_index, output anim_period, output auto_advance,
                    output channel_sel, output hue_active, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input anim_index, input anim_period, input auto_advance,
                    input channel_sel, input hue_active, output ready);
endinterface

[rtl/ecmc_cfg_regs.sv]
// ============================================================================
// ecmc_cfg_regs
// APB-style configuration registers, one per word address.
// ============================================================================
module ecmc_cfg_regs
    import ecmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output ecmc_cfg_t             cfg
);

    ecmc_cfg_t  cfg_reg;
    ecmc_cfg_t  cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_HOLD_TICKS:   cfg_next.hold_ticks   = pwdata[6:0];
                REG_STEP_DETENTS: cfg_next.step_detents = pwdata[6:0];
                REG_HUE_DETENTS:  cfg_next.hue_detents  = pwdata[6:0];
                REG_ANIM_COUNT:   cfg_next.anim_count   = pwdata[3:0];
                REG_PERIOD_MIN:   cfg_next.period_min   = pwdata[5:0];
                REG_PERIOD_MAX:   cfg_next.period_max   = pwdata[5:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_HOLD_TICKS:   prdata = {25'd0, cfg_reg.hold_ticks};
            REG_STEP_DETENTS: prdata = {25'd0, cfg_reg.step_detents};
            REG_HUE_DETENTS:  prdata = {25'd0, cfg_reg.hue_detents};
            REG_ANIM_COUNT:   prdata = {28'd0, cfg_reg.anim_count};
            REG_PERIOD_MIN:   prdata = {26'd0, cfg_reg.period_min};
            REG_PERIOD_MAX:   prdata = {26'd0, cfg_reg.period_max};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= HOLD_TICKS_RST;
            cfg_reg.step_detents <= STEP_DETENTS_RST;
            cfg_reg.hue_detents  <= HUE_DETENTS_RST;
            cfg_reg.anim_count   <= ANIM_COUNT_RST;
            cfg_reg.period_min   <= PERIOD_MIN_RST;
            cfg_reg.period_max   <= PERIOD_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/ecmc_ctrl.sv]
// ============================================================================
// ecmc_ctrl
// Control state and its update for one request item.
// ============================================================================
module ecmc_ctrl
    import ecmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  ecmc_item_t   item,
    input  ecmc_cfg_t    cfg,
    output ecmc_result_t result
);

    logic [1:0]        prev_phase_reg,   prev_phase_next;
    logic [7:0]        acc_reg,          acc_next;
    logic [6:0]        hold_reg,         hold_next;
    logic [7:0]        level_reg,        level_next;
    logic [1:0]        chan_reg,         chan_next;
    logic              hue_reg,          hue_next;
    logic [7:0]        colour_reg [3];
    logic [7:0]        colour_next [3];
    logic [2:0]        anim_reg,         anim_next;
    logic [5:0]        period_reg,       period_next;
    logic              advance_reg,      advance_next;

    logic [1:0]        phase;
    logic signed [1:0] d;
    logic              d_pos;
    logic              d_neg;
    logic [7:0]        d_ext;
    logic [7:0]        acc_sum;
    logic [7:0]        mag;
    logic [6:0]        hold_pin;
    logic              held;
    logic              step_hit;
    logic              hue_hit;
    logic [1:0]        chan_inc;
    logic [7:0]        level_clamp;
    logic [7:0]        level_step;
    logic [3:0]        anim_wrap;
    ecmc_rgb_t         rgb;

    assign phase    = {~item.enc_b_level, ~item.enc_a_level};
    assign d        = STEP_TABLE[{prev_phase_reg, phase}];
    assign d_pos    = (d == 2'sb01);
    assign d_neg    = d[1];
    assign d_ext    = {{6{d[1]}}, d};
    assign acc_sum  = acc_reg + d_ext;
    assign mag      = acc_sum[7] ? (~acc_sum + 8'd1) : acc_sum;
    assign hold_pin = (hold_reg == '0 && !item.button_level) ? cfg.hold_ticks : hold_reg;
    assign held     = (hold_pin != '0);
    assign step_hit = (mag >= {1'b0, cfg.step_detents});
    assign hue_hit  = (mag >= {1'b0, cfg.hue_detents});
    assign chan_inc = (chan_reg >= CHAN_LAST) ? 2'd0 : chan_reg + 2'd1;
    assign level_clamp = (level_reg > LEVEL_MAX) ? LEVEL_MAX : level_reg;
    assign anim_wrap   = {1'b0, anim_reg} + 4'd1;

    // The level stepped in hue mode starts from the next channel when hue
    // mode is being entered.
    always_comb
    begin
        if (hue_reg)
        begin
            level_step = level_reg + d_ext;
        end
        else
        begin
            level_step = {3'd0, colour_reg[chan_inc][7:3]} + d_ext;
        end
    end

    assign rgb = hue_wheel({level_step[5:0], 2'b00});

    always_comb
    begin
        prev_phase_next = prev_phase_reg;
        acc_next        = acc_reg;
        hold_next       = hold_reg;
        level_next      = level_reg;
        chan_next       = chan_reg;
        hue_next        = hue_reg;
        colour_next     = colour_reg;
        anim_next       = anim_reg;
        period_next     = period_reg;
        advance_next    = advance_reg;

        unique case (item.req_type)
            REQ_PIN:
            begin
                prev_phase_next = phase;
                acc_next        = acc_sum;
                hold_next       = hold_pin;
                if (item.auto_mode)
                begin
                    if (held)
                    begin
                        if (step_hit)
                        begin
                            if (d_neg && period_reg > cfg.period_min)
                            begin
                                period_next = period_reg - 6'd1;
                            end
                            else if (d_pos &&
                                     ({1'b0, period_reg} + 7'd1) < {1'b0, cfg.period_max})
                            begin
                                period_next = period_reg + 6'd1;
                            end
                            acc_next     = '0;
                            advance_next = 1'b0;
                        end
                        else
                        begin
                            advance_next = 1'b1;
                        end
                    end
                    else if (step_hit)
                    begin
                        advance_next = 1'b0;
                        if (d_neg && anim_reg != '0)
                        begin
                            anim_next = anim_reg - 3'd1;
                        end
                        else if (d_pos && anim_wrap < cfg.anim_count && anim_reg != ANIM_LAST)
                        begin
                            anim_next = anim_reg + 3'd1;
                        end
                        acc_next = '0;
                    end
                end
                else if (held)
                begin
                    if (!hue_reg)
                    begin
                        chan_next  = chan_inc;
                        level_next = {3'd0, colour_reg[chan_inc][7:3]};
                    end
                    if (hue_reg ? step_hit : hue_hit)
                    begin
                        level_next     = level_step;
                        acc_next       = '0;
                        colour_next[0] = rgb.red;
                        colour_next[1] = rgb.green;
                        colour_next[2] = rgb.blue;
                        hue_next       = 1'b1;
                        chan_next      = 2'd0;
                    end
                end
                else if (step_hit)
                begin
                    // The clamp is kept even when a step at a bound is refused.
                    level_next = level_clamp;
                    if (!((level_clamp == '0 && d_neg) || (level_clamp == LEVEL_MAX && d_pos)))
                    begin
                        level_next = level_clamp + d_ext;
                        acc_next   = '0;
                        hue_next   = 1'b0;
                        if (chan_reg <= CHAN_LAST)
                        begin
                            colour_next[chan_reg] = {level_next[4:0], 3'b000};
                        end
                    end
                end
            end
            REQ_TICK:
            begin
                if (hold_reg != '0)
                begin
                    hold_next = hold_reg - 7'd1;
                end
            end
            REQ_WRAP:
            begin
                if (advance_reg)
                begin
                    anim_next = (anim_wrap >= cfg.anim_count || anim_reg == ANIM_LAST)
                                ? 3'd0 : anim_wrap[2:0];
                end
            end
            default:
            begin
                advance_next = advance_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg <= '0;
            acc_reg        <= '0;
            hold_reg       <= '0;
            level_reg      <= LEVEL_RST;
            chan_reg       <= '0;
            hue_reg        <= 1'b0;
            colour_reg[0]  <= RED_RST;
            colour_reg[1]  <= '0;
            colour_reg[2]  <= '0;
            anim_reg       <= '0;
            period_reg     <= PERIOD_RST;
            advance_reg    <= 1'b1;
        end
        else if (fire)
        begin
            prev_phase_reg <= prev_phase_next;
            acc_reg        <= acc_next;
            hold_reg       <= hold_next;
            level_reg      <= level_next;
            chan_reg       <= chan_next;
            hue_reg        <= hue_next;
            colour_reg     <= colour_next;
            anim_reg       <= anim_next;
            period_reg     <= period_next;
            advance_reg    <= advance_next;
        end
    end

    assign result.red          = colour_reg[0];
    assign result.green        = colour_reg[1];
    assign result.blue         = colour_reg[2];
    assign result.anim_index   = anim_reg;
    assign result.anim_period  = period_reg;
    assign result.auto_advance = advance_reg;
    assign result.channel_sel  = chan_reg;
    assign result.hue_active   = hue_reg;

endmodule

[rtl/encoder_color_and_mode_control.sv]
// ============================================================================
// encoder_color_and_mode_control
// Rotary encoder and push-button control of RGB colour and animation mode.
// ============================================================================
//
//  Channel   Direction  Handshake            Carries
//  req       in         valid / ready        req_type, encoder pins, button, mode
//  res       out        valid / ready        colour, animation, channel, hue flag
//  apb       in         psel/penable/pready  six configuration registers
//
// Each accepted item waits in an input register and, at the next edge at which
// the result stage is free, updates the control state, which is itself the
// result register. Without stalls an item passes from the input register into
// the result register and is shown there until it is taken. One item per cycle
// is sustained while results are taken. While a result waits, the input
// register still takes one further item. Reset is asynchronous and returns
// state, valid flags and configuration to their default values; no clearing pass.
//
module encoder_color_and_mode_control
    import ecmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ecmc_req_if.sink              req,
    ecmc_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    ecmc_cfg_t    cfg;
    ecmc_result_t result;

    // Input register: the accepted item waits here for its update cycle.
    logic         in_valid_reg, in_valid_next;
    ecmc_item_t   in_item_reg;
    logic         res_valid_reg, res_valid_next;
    logic         out_ready;
    logic         fire;

    // The result stage can take a new item when it is empty or being read.
    assign out_ready = !res_valid_reg || res.ready;
    assign fire      = in_valid_reg && out_ready;
    assign req.ready = !in_valid_reg || out_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req.valid && req.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload only; no reset needed.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.req_type     <= req.req_type;
            in_item_reg.enc_a_level  <= req.enc_a_level;
            in_item_reg.enc_b_level  <= req.enc_b_level;
            in_item_reg.button_level <= req.button_level;
            in_item_reg.auto_mode    <= req.auto_mode;
        end
    end

    ecmc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The state registers only move when an item passes into the result
    // stage, so the shown result holds steady while it is stalled.
    ecmc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign res.valid        = res_valid_reg;
    assign res.red          = result.red;
    assign res.green        = result.green;
    assign res.blue         = result.blue;
    assign res.anim_index   = result.anim_index;
    assign res.anim_period  = result.anim_period;
    assign res.auto_advance = result.auto_advance;
    assign res.channel_sel  = result.channel_sel;
    assign res.hue_active   = result.hue_active;

endmodule

[rtl/ecmc_checker.sv]
// ============================================================================
// ecmc_checker
// Port-level checks of the encoder colour and mode control, bound to the top.
// ============================================================================
module ecmc_checker
    import ecmc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_channel_sel,
    input logic        res_hue_active,
    input logic [36:0] res_data
);

    // A waiting result keeps its value until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // A new result follows an item accepted into the input register.
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without an accepted item");

    // With no result waiting the block always takes an item.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled with empty result stage");

    // A colour set from the hue wheel leaves channel red selected.
    a_hue_chan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_hue_active |-> res_channel_sel == 2'd0)
        else $error("hue colour with a channel other than red");

endmodule

bind encoder_color_and_mode_control ecmc_checker u_ecmc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_channel_sel (res.channel_sel),
    .res_hue_active  (res.hue_active),
    .res_data        ({res.red, res.green, res.blue, res.anim_index,
                       res.anim_period, res.auto_advance, res.channel_sel,
                       res.hue_active})
);
